// ===== rtl/lsch_pkg.sv =====
// ----------------------------------------------------------------------------
// lsch_pkg
// Shared constants, types and state codes of the lottery scheduler.
// ----------------------------------------------------------------------------
package lsch_pkg;

    localparam int MAX_JOBS    = 8;
    localparam int JOB_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int JOB_CNT_W   = $clog2(MAX_JOBS + 1);

    localparam int SLOT_W      = 3;
    localparam int ID_W        = 8;
    localparam int TICKET_W    = 16;
    localparam int DUR_W       = 16;
    localparam int RAND_W      = 31;
    localparam int QUANTUM_W   = 16;
    localparam int WT_W        = 19;
    localparam int TIME_W      = 32;

    localparam int TOTAL_W     = TICKET_W + $clog2(MAX_JOBS);
    localparam int DIV_CNT_W   = $clog2(RAND_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(1);

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_DRAW = 1'b1
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t           kind;
        logic                slot_ok;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     job_id;
        logic [TICKET_W-1:0] tickets;
        logic [DUR_W-1:0]    duration;
        logic [RAND_W-1:0]   random_value;
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_CHECK,
        ST_EMPTY,
        ST_DIV,
        ST_SCAN,
        ST_RUN
    } back_state_t;

endpackage

// ===== rtl/lsch_front.sv =====
// ----------------------------------------------------------------------------
// lsch_front
// Accepts input items, classifies them as load or draw, and holds them in a
// short command queue for the execution engine.
// ----------------------------------------------------------------------------
module lsch_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          action,
    input  logic [lsch_pkg::SLOT_W-1:0]   slot,
    input  logic [lsch_pkg::ID_W-1:0]     job_id,
    input  logic [lsch_pkg::TICKET_W-1:0] tickets,
    input  logic [lsch_pkg::DUR_W-1:0]    duration,
    input  logic [lsch_pkg::RAND_W-1:0]   random_value,
    output logic                          cmd_valid,
    output lsch_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);
    import lsch_pkg::*;

    cmd_t                queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    cmd_t                in_cmd;
    logic                push;
    logic                pop;

    // classify the incoming item
    always_comb
    begin
        in_cmd.kind         = cmd_kind_t'(action);
        in_cmd.slot_ok      = (int'(slot) < MAX_JOBS);
        in_cmd.slot         = slot;
        in_cmd.job_id       = job_id;
        in_cmd.tickets      = tickets;
        in_cmd.duration     = duration;
        in_cmd.random_value = random_value;
    end

    assign item_stall = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign pop        = cmd_pop && cmd_valid;
    assign cmd        = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/lsch_mod_unit.sv =====
// ----------------------------------------------------------------------------
// lsch_mod_unit
// Serial restoring modulo unit: one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module lsch_mod_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lsch_pkg::RAND_W-1:0]  dividend,
    input  logic [lsch_pkg::TOTAL_W-1:0] divisor,
    output logic                         done,
    output logic [lsch_pkg::TOTAL_W-1:0] remainder
);
    import lsch_pkg::*;

    logic [RAND_W-1:0]    dvd_reg;
    logic [TOTAL_W-1:0]   dsr_reg;
    logic [TOTAL_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TOTAL_W:0]     trial;

    // shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = TOTAL_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(RAND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/lsch_back.sv =====
// ----------------------------------------------------------------------------
// lsch_back
// Execution engine: job table, ticket sum, modulo draw, slot scan, run
// accounting and the result register.
// ----------------------------------------------------------------------------
module lsch_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  lsch_pkg::cmd_t                 cmd,
    output logic                           cmd_pop,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsch_pkg::QUANTUM_W-1:0] cfg_quantum,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           granted,
    output logic [lsch_pkg::ID_W-1:0]      winner_id,
    output logic [lsch_pkg::WT_W-1:0]      drawn_ticket,
    output logic [lsch_pkg::TIME_W-1:0]    time_now,
    output logic                           job_finished,
    output logic [lsch_pkg::TIME_W-1:0]    turnaround_time,
    output logic [lsch_pkg::TIME_W-1:0]    response_time,
    output logic                           idle
);
    import lsch_pkg::*;

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [JOB_CNT_W-1:0] idx_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   acc_reg;
    logic [TOTAL_W-1:0]   ticket_reg;
    logic [JOB_W-1:0]     win_reg;
    logic [TIME_W-1:0]    clock_reg;
    logic [QUANTUM_W-1:0] quantum_reg;

    logic [ID_W-1:0]      job_id_reg    [MAX_JOBS];
    logic [TICKET_W-1:0]  tickets_reg   [MAX_JOBS];
    logic [DUR_W-1:0]     remain_reg    [MAX_JOBS];
    logic                 has_run_reg   [MAX_JOBS];
    logic [TIME_W-1:0]    first_run_reg [MAX_JOBS];

    logic                 result_valid_reg;
    logic                 granted_reg;
    logic [ID_W-1:0]      winner_id_reg;
    logic [WT_W-1:0]      drawn_ticket_reg;
    logic [TIME_W-1:0]    time_now_reg;
    logic                 job_finished_reg;
    logic [TIME_W-1:0]    turnaround_reg;
    logic [TIME_W-1:0]    response_reg;
    logic                 idle_reg;

    logic                 idx_clear;
    logic                 sum_en;
    logic                 div_start;
    logic                 scan_en;
    logic                 load_commit;
    logic                 empty_commit;
    logic                 run_commit;

    logic                 div_done;
    logic [TOTAL_W-1:0]   div_rem;

    logic [JOB_W-1:0]     rd_idx;
    logic [JOB_W-1:0]     load_idx;
    logic [DUR_W-1:0]     rd_remain;
    logic                 rd_active;
    logic [TOTAL_W-1:0]   rd_tickets;
    logic                 last_idx;
    logic [TOTAL_W-1:0]   acc_sum;
    logic                 hit;
    logic                 out_free;
    logic [DUR_W-1:0]     run_len;
    logic [DUR_W-1:0]     remain_new;
    logic [TIME_W:0]      clock_sum;
    logic [TIME_W-1:0]    clock_new;
    logic [TIME_W-1:0]    first_val;
    logic                 finished;

    lsch_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cmd_reg.random_value),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // single read port into the job table
    assign rd_idx     = (state_reg == ST_RUN) ? win_reg : idx_reg[JOB_W-1:0];
    assign load_idx   = JOB_W'(cmd_reg.slot);
    assign rd_remain  = remain_reg[rd_idx];
    assign rd_active  = (rd_remain != '0);
    assign rd_tickets = rd_active ? TOTAL_W'(tickets_reg[rd_idx]) : '0;
    assign last_idx   = (idx_reg == JOB_CNT_W'(MAX_JOBS - 1));
    assign acc_sum    = acc_reg + rd_tickets;
    assign hit        = rd_active && (acc_sum > ticket_reg);
    assign out_free   = !result_valid_reg || !result_stall;

    // run accounting for the winner
    always_comb
    begin
        run_len    = (quantum_reg < rd_remain) ? quantum_reg : rd_remain;
        remain_new = rd_remain - run_len;
        clock_sum  = {1'b0, clock_reg} + (TIME_W + 1)'(run_len);
        clock_new  = clock_sum[TIME_W] ? '1 : clock_sum[TIME_W-1:0];
        first_val  = has_run_reg[rd_idx] ? first_run_reg[rd_idx] : clock_reg;
        finished   = (remain_new == '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.kind == CMD_LOAD) ? ST_LOAD : ST_SUM;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                if (last_idx)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (total_reg == '0) ? ST_EMPTY : ST_DIV;
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_RUN;
                end
                else if (last_idx)
                begin
                    state_next = ST_EMPTY;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb
    begin
        cmd_pop      = 1'b0;
        idx_clear    = 1'b0;
        sum_en       = 1'b0;
        div_start    = 1'b0;
        scan_en      = 1'b0;
        load_commit  = 1'b0;
        empty_commit = 1'b0;
        run_commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_pop   = cmd_valid;
                idx_clear = 1'b1;
            end
            ST_LOAD:
            begin
                load_commit = out_free;
            end
            ST_SUM:
            begin
                sum_en = 1'b1;
            end
            ST_CHECK:
            begin
                idx_clear = 1'b1;
                div_start = (total_reg != '0);
            end
            ST_EMPTY:
            begin
                empty_commit = out_free;
            end
            ST_DIV:
            begin
            end
            ST_SCAN:
            begin
                scan_en = 1'b1;
            end
            ST_RUN:
            begin
                run_commit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            total_reg   <= '0;
            acc_reg     <= '0;
            clock_reg   <= '0;
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                quantum_reg <= cfg_quantum;
            end
            if (idx_clear)
            begin
                idx_reg <= '0;
                acc_reg <= '0;
                if (state_reg == ST_IDLE)
                begin
                    total_reg <= '0;
                end
            end
            else if (sum_en)
            begin
                idx_reg   <= idx_reg + 1'b1;
                total_reg <= total_reg + rd_tickets;
            end
            else if (scan_en)
            begin
                idx_reg <= idx_reg + 1'b1;
                acc_reg <= acc_sum;
            end
            if (run_commit)
            begin
                clock_reg <= clock_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (div_done)
        begin
            ticket_reg <= div_rem;
        end
        if (scan_en && hit)
        begin
            win_reg <= rd_idx;
        end
    end

    // job table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                job_id_reg[i]  <= '0;
                tickets_reg[i] <= '0;
                remain_reg[i]  <= '0;
                has_run_reg[i] <= 1'b0;
            end
        end
        else if (load_commit && cmd_reg.slot_ok)
        begin
            job_id_reg[load_idx]  <= cmd_reg.job_id;
            tickets_reg[load_idx] <= cmd_reg.tickets;
            remain_reg[load_idx]  <= cmd_reg.duration;
            has_run_reg[load_idx] <= 1'b0;
        end
        else if (run_commit)
        begin
            remain_reg[rd_idx]  <= remain_new;
            has_run_reg[rd_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_commit && !has_run_reg[rd_idx])
        begin
            first_run_reg[rd_idx] <= clock_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_commit || empty_commit || run_commit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_commit || empty_commit)
        begin
            granted_reg      <= 1'b0;
            winner_id_reg    <= '0;
            drawn_ticket_reg <= '0;
            time_now_reg     <= clock_reg;
            job_finished_reg <= 1'b0;
            turnaround_reg   <= '0;
            response_reg     <= '0;
            idle_reg         <= empty_commit;
        end
        else if (run_commit)
        begin
            granted_reg      <= 1'b1;
            winner_id_reg    <= job_id_reg[rd_idx];
            drawn_ticket_reg <= WT_W'(ticket_reg);
            time_now_reg     <= clock_new;
            job_finished_reg <= finished;
            turnaround_reg   <= finished ? clock_new : '0;
            response_reg     <= finished ? first_val : '0;
            idle_reg         <= 1'b0;
        end
    end

    assign cfg_ready       = 1'b1;
    assign result_valid    = result_valid_reg;
    assign granted         = granted_reg;
    assign winner_id       = winner_id_reg;
    assign drawn_ticket    = drawn_ticket_reg;
    assign time_now        = time_now_reg;
    assign job_finished    = job_finished_reg;
    assign turnaround_time = turnaround_reg;
    assign response_time   = response_reg;
    assign idle            = idle_reg;

endmodule

// ===== rtl/lottery_scheduler.sv =====
// ----------------------------------------------------------------------------
// lottery_scheduler
// Flow: a load passes the IDLE and LOAD states into the result register;
// a draw runs a ticket sum over all 8 slots, a 31-step serial
// modulo unit and a scan of up to 8 slots, one slot per cycle; a draw with
// no active tickets ends right after the sum and the check state.
// Throughput: one item at a time in the engine; a 2-entry queue takes items
// meanwhile. Reset clears the job table, the clock and sets quantum to 1.
// ----------------------------------------------------------------------------
module lottery_scheduler
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           action,
    input  logic [lsch_pkg::SLOT_W-1:0]    slot,
    input  logic [lsch_pkg::ID_W-1:0]      job_id,
    input  logic [lsch_pkg::TICKET_W-1:0]  tickets,
    input  logic [lsch_pkg::DUR_W-1:0]     duration,
    input  logic [lsch_pkg::RAND_W-1:0]    random_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsch_pkg::QUANTUM_W-1:0] cfg_quantum,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           granted,
    output logic [lsch_pkg::ID_W-1:0]      winner_id,
    output logic [lsch_pkg::WT_W-1:0]      drawn_ticket,
    output logic [lsch_pkg::TIME_W-1:0]    time_now,
    output logic                           job_finished,
    output logic [lsch_pkg::TIME_W-1:0]    turnaround_time,
    output logic [lsch_pkg::TIME_W-1:0]    response_time,
    output logic                           idle
);
    import lsch_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    lsch_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .slot         (slot),
        .job_id       (job_id),
        .tickets      (tickets),
        .duration     (duration),
        .random_value (random_value),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    lsch_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_quantum     (cfg_quantum),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .granted         (granted),
        .winner_id       (winner_id),
        .drawn_ticket    (drawn_ticket),
        .time_now        (time_now),
        .job_finished    (job_finished),
        .turnaround_time (turnaround_time),
        .response_time   (response_time),
        .idle            (idle)
    );

endmodule
